// ===== rtl/core/cartridge_bank_mapper_with_irq_counter_core_defines.svh =====
// assertion macros for the cartridge bank mapper core
// no dependencies; expects clk and rst_n in the including scope
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_COUNTER_CORE_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_COUNTER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CBM_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cbm assertion failed");
`define CBM_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cbm assertion failed");
`else
`define CBM_ASSERT_IMP(lbl, pre, post)
`define CBM_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/cbm_pkg.sv =====
// constants and codes for the cartridge bank mapper core
// no dependencies
package cbm_pkg;

    localparam int IN_W  = 56;
    localparam int OUT_W = 24;
    localparam int NUM_BANKS = 11;

    // item kinds
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_CYCLES = 2'd1;
    localparam logic [1:0] MODE_LINE   = 2'd2;
    localparam logic [1:0] MODE_LOOKUP = 2'd3;

    // write decode, address masked with 0xF001
    localparam logic [15:0] DEC_MASK    = 16'hF001;
    localparam logic [15:0] REG_COMMAND = 16'h8000;
    localparam logic [15:0] REG_BANK    = 16'h8001;
    localparam logic [15:0] REG_MIRROR  = 16'hA000;
    localparam logic [15:0] REG_LATCH   = 16'hC000;
    localparam logic [15:0] REG_RELOAD  = 16'hC001;
    localparam logic [15:0] REG_IRQ_OFF = 16'hE000;
    localparam logic [15:0] REG_IRQ_ON  = 16'hE001;

    localparam logic [8:0] SKIP_LINE = 9'd240;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_COUNT  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

endpackage

// ===== rtl/core/cartridge_bank_mapper_with_irq_counter_core.sv =====
// Writes, scanline events and lookups go from accept through ST_EXEC and ST_FINISH
// to the result register; cycle reports in cycle mode also run ST_COUNT for the
// n = (prescaler + cycles) >> 2 counter decrements, up to 256, all run through one
// shared 8-bit decrementer. ST_FINISH holds while the output register is full and
// not taken; the finished result waits in that register while the next item is taken.
// Reset (rst_n low, async): bank registers 0xFF, other mapper state and the sequencer zero, no result.
`include "cartridge_bank_mapper_with_irq_counter_core_defines.svh"

module cartridge_bank_mapper_with_irq_counter_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // cpu_address[15:0], data[23:16], cycles[33:24], scanline[42:34], ppu_address[55:43]
    input  logic [cbm_pkg::IN_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // irq_line[0], mirror_select[1], chr_bank[9:2], prg_bank[17:10],
    // prg_region[19:18], zero fill[23:20]
    output logic [cbm_pkg::OUT_W-1:0] m_tdata
);
    import cbm_pkg::*;

    logic [1:0]  state_reg, state_next;

    // latched item
    logic [1:0]  mode_reg;
    logic [15:0] cpu_reg;
    logic [7:0]  data_reg;
    logic [9:0]  cycles_reg;
    logic [8:0]  line_reg;
    logic [12:0] ppu_reg;

    // mapper state
    logic [7:0]  bank_reg [NUM_BANKS];
    logic [7:0]  command_reg;
    logic        mirror_reg;
    logic        reload_pending_reg;
    logic        cycle_mode_reg;
    logic [7:0]  counter_reg;
    logic [7:0]  latch_reg;
    logic        irq_enable_reg;
    logic [1:0]  prescaler_reg;
    logic        irq_level_reg;
    logic [8:0]  steps_reg;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [7:0]  dec_value;
    logic        dec_irq;
    logic [10:0] cycle_total;
    logic [15:0] wr_code;
    logic        out_load;
    logic [7:0]  chr_value;
    logic [7:0]  prg_value;
    logic [1:0]  region_value;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // shared decrement unit
    assign dec_value = counter_reg - 8'd1;
    assign dec_irq   = (dec_value == 8'hFF) && irq_enable_reg;

    assign cycle_total = {9'd0, prescaler_reg} + {1'b0, cycles_reg};
    assign wr_code     = cpu_reg & DEC_MASK;
    assign out_load    = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (mode_reg == MODE_CYCLES && cycle_mode_reg && cycle_total[10:2] != 9'd0)
                    state_next = ST_COUNT;
                else
                    state_next = ST_FINISH;
            end
            ST_COUNT:
            begin
                if (steps_reg == 9'd1)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg   <= s_tuser;
            cpu_reg    <= s_tdata[15:0];
            data_reg   <= s_tdata[23:16];
            cycles_reg <= s_tdata[33:24];
            line_reg   <= s_tdata[42:34];
            ppu_reg    <= s_tdata[55:43];
        end
    end

    // mapper state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANKS; i++)
                bank_reg[i] <= 8'hFF;
            command_reg        <= '0;
            mirror_reg         <= 1'b0;
            reload_pending_reg <= 1'b0;
            cycle_mode_reg     <= 1'b0;
            counter_reg        <= '0;
            latch_reg          <= '0;
            irq_enable_reg     <= 1'b0;
            prescaler_reg      <= '0;
            irq_level_reg      <= 1'b0;
            steps_reg          <= '0;
        end
        else if (state_reg == ST_EXEC)
        begin
            case (mode_reg)
                MODE_WRITE:
                begin
                    case (wr_code)
                        REG_COMMAND: command_reg <= data_reg;
                        REG_BANK:
                        begin
                            if (command_reg[3:0] == 4'hF)
                                bank_reg[10] <= data_reg;
                            else if (command_reg[3:0] < 4'd10)
                                bank_reg[command_reg[3:0]] <= data_reg;
                        end
                        REG_MIRROR: mirror_reg <= data_reg[0];
                        REG_LATCH:
                        begin
                            latch_reg <= data_reg;
                            if (reload_pending_reg)
                                counter_reg <= data_reg;
                        end
                        REG_RELOAD:
                        begin
                            reload_pending_reg <= 1'b1;
                            counter_reg        <= latch_reg;
                            cycle_mode_reg     <= data_reg[0];
                        end
                        REG_IRQ_OFF:
                        begin
                            irq_enable_reg <= 1'b0;
                            irq_level_reg  <= 1'b0;
                            if (reload_pending_reg)
                                counter_reg <= latch_reg;
                        end
                        REG_IRQ_ON:
                        begin
                            irq_enable_reg <= 1'b1;
                            if (reload_pending_reg)
                                counter_reg <= latch_reg;
                        end
                        default: ;
                    endcase
                end
                MODE_CYCLES:
                begin
                    if (cycle_mode_reg)
                    begin
                        prescaler_reg <= cycle_total[1:0];
                        steps_reg     <= cycle_total[10:2];
                    end
                end
                MODE_LINE:
                begin
                    if (!cycle_mode_reg && line_reg != SKIP_LINE)
                    begin
                        counter_reg        <= dec_value;
                        reload_pending_reg <= dec_irq;
                        if (dec_irq)
                            irq_level_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_COUNT)
        begin
            // one decrement per cycle
            counter_reg <= dec_value;
            steps_reg   <= steps_reg - 9'd1;
            if (dec_irq)
                irq_level_reg <= 1'b1;
        end
    end

    // character bank lookup
    always_comb
    begin
        case (ppu_reg[12:10])
            3'd0: chr_value = command_reg[5] ? bank_reg[0] : {bank_reg[0][7:1], 1'b0};
            3'd1: chr_value = command_reg[5] ? bank_reg[8] : {bank_reg[0][7:1], 1'b1};
            3'd2: chr_value = command_reg[5] ? bank_reg[1] : {bank_reg[1][7:1], 1'b0};
            3'd3: chr_value = command_reg[5] ? bank_reg[9] : {bank_reg[1][7:1], 1'b1};
            3'd4: chr_value = bank_reg[2];
            3'd5: chr_value = bank_reg[3];
            3'd6: chr_value = bank_reg[4];
            3'd7: chr_value = bank_reg[5];
            default: chr_value = bank_reg[2];
        endcase
    end

    // program bank lookup
    always_comb
    begin
        case (cpu_reg[15:13])
            3'd7:
            begin
                region_value = 2'd2;
                prg_value    = 8'd0;
            end
            3'd6:
            begin
                region_value = 2'd1;
                prg_value    = bank_reg[10];
            end
            3'd5:
            begin
                region_value = 2'd1;
                prg_value    = bank_reg[7];
            end
            3'd4:
            begin
                region_value = 2'd1;
                prg_value    = bank_reg[6];
            end
            default:
            begin
                region_value = 2'd0;
                prg_value    = 8'd0;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {4'd0, region_value, prg_value, chr_value,
                             ~mirror_reg, irq_level_reg};
    end

    // checks
    `CBM_ASSERT_IMP(a_count_nonzero, state_reg == ST_COUNT, steps_reg != 9'd0)
    `CBM_ASSERT_IMP(a_irq_needs_enable, $rose(irq_level_reg), irq_enable_reg)
    `CBM_ASSERT_NXT(a_finish_delivers, out_load, out_valid_reg && state_reg == ST_IDLE)

endmodule
